// ===== design/lph_pkg.sv =====
// Shared widths, codes and control/status types of the linear probing hash table.
`default_nettype none

package lph_pkg;

    localparam int KEY_W      = 32;
    localparam int PAY_W      = 32;
    localparam int OPC_W      = 2;
    localparam int STAT_W     = 3;
    localparam int BUCKET_W   = 11;
    localparam int HOME_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Command codes.
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPC_W-1:0] OP_PROBE  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_MATCH    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOMATCH  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_FACTOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_KEY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIQUE_KEYS  = 2'd3;

    localparam logic [KEY_W-1:0]    HASH_FACTOR_RST  = 32'd2654435761;
    localparam logic [BUCKET_W-1:0] BUCKET_COUNT_RST = 11'd512;

    // floor(x / 5) = (x * 52429) >> 18 for every x below 2^18.
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    typedef enum logic [1:0] {
        RD_HOME,
        RD_IDX,
        RD_NEXT
    } lph_rd_sel_t;

    typedef struct packed {
        logic              load;
        logic              idx_home;
        logic              idx_clear;
        logic              idx_inc;
        lph_rd_sel_t       rd_sel;
        logic              wr_insert;
        logic              wr_clear;
        logic              cnt_clear;
        logic              cnt_inc;
        logic              pend_load;
        logic              emit;
        logic              emit_pend;
        logic [STAT_W-1:0] emit_status;
        logic              emit_last;
    } lph_ctl_t;

    typedef struct packed {
        logic [OPC_W-1:0] cmd_opcode;
        logic [OPC_W-1:0] op;
        logic             home_ok;
        logic             at_end;
        logic             at_depth_end;
        logic             slot_empty;
        logic             slot_match;
        logic             cnt_full;
        logic             have_pend;
        logic             unique_keys;
        logic             out_free;
    } lph_sts_t;

endpackage

`default_nettype wire

// ===== design/lph_cmd_if.sv =====
// Command channel: opcode, key and payload of one input item.
`default_nettype none

interface lph_cmd_if
    import lph_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/lph_res_if.sv =====
// Result channel: one result item of a clear, insert or probe.
`default_nettype none

interface lph_res_if
    import lph_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  match_key;
    logic [PAY_W-1:0]  probe_payload;
    logic [PAY_W-1:0]  stored_payload;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, output match_key, output probe_payload,
                    output stored_payload, output status, output last, input ready);
    modport sink   (input valid, input match_key, input probe_payload,
                    input stored_payload, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== design/lph_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

`default_nettype wire

// ===== design/lph_datapath.sv =====
// Datapath: configuration registers, hash pipeline, slot table, walk counter and result register.
`default_nettype none

module lph_datapath
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_MATCHES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OPC_W-1:0]      opcode,
    input  wire logic [KEY_W-1:0]      key,
    input  wire logic [PAY_W-1:0]      payload,
    input  wire lph_ctl_t              ctl,
    output lph_sts_t                   sts,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic [KEY_W-1:0]           match_key,
    output logic [PAY_W-1:0]           probe_payload,
    output logic [PAY_W-1:0]           stored_payload,
    output logic [STAT_W-1:0]          status,
    output logic                       last
);
    localparam int ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int LEN_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W    = (LEN_W > HOME_W) ? LEN_W : HOME_W;
    localparam int CNT_W    = $clog2(MAX_MATCHES + 1);
    localparam int SLOT_W   = KEY_W + PAY_W;
    localparam int SCALED_W = BUCKET_W + 3;
    localparam int PROD_W   = SCALED_W + 16;
    localparam int QUOT_W   = PROD_W - DIV5_SHIFT;
    localparam int HPROD_W  = KEY_W + BUCKET_W;

    logic [KEY_W-1:0]    factor_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [KEY_W-1:0]    empty_key_reg;
    logic                unique_reg;

    logic [OPC_W-1:0]    op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PAY_W-1:0]    pay_reg;
    logic [KEY_W-1:0]    hash_reg;
    logic [HOME_W-1:0]   home_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [IDX_W-1:0]    idx_plus1;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [PAY_W-1:0]    pend_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    logic [SCALED_W-1:0] scaled_len;
    logic [PROD_W-1:0]   len_prod;
    logic [QUOT_W-1:0]   len_quot;
    logic [HPROD_W-1:0]  home_prod;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SLOT_W-1:0]   rd_data;
    logic [KEY_W-1:0]    slot_key;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg    <= HASH_FACTOR_RST;
            bucket_reg    <= BUCKET_COUNT_RST;
            empty_key_reg <= '0;
            unique_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HASH_FACTOR:  factor_reg    <= cfg_data[KEY_W-1:0];
                CFG_BUCKET_COUNT: bucket_reg    <= cfg_data[BUCKET_W-1:0];
                CFG_EMPTY_KEY:    empty_key_reg <= cfg_data[KEY_W-1:0];
                CFG_UNIQUE_KEYS:  unique_reg    <= cfg_data[0];
            endcase
        end
    end

    // Usable length floor(1.2 * bucket_count), capped at the table depth.
    always_comb
    begin
        scaled_len = (SCALED_W'(bucket_reg) << 2) + (SCALED_W'(bucket_reg) << 1);
        len_prod   = PROD_W'(scaled_len) * PROD_W'(DIV5_MUL);
        len_quot   = len_prod[PROD_W-1:DIV5_SHIFT];
        if (32'(len_quot) > 32'(TABLE_DEPTH))
        begin
            len_next = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            len_next = LEN_W'(len_quot);
        end
    end

    assign home_prod = HPROD_W'(hash_reg) * HPROD_W'(bucket_reg);

    // Item fields, loaded on ctl.load, and the two hash stages, which run every cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            pay_reg <= payload;
        end
        hash_reg <= key_reg * factor_reg;
        home_reg <= home_prod[HPROD_W-1:KEY_W];
        len_reg  <= len_next;
        if (ctl.pend_load)
        begin
            pend_reg <= rd_data[SLOT_W-1:KEY_W];
        end
    end

    assign idx_plus1 = idx_reg + IDX_W'(1);

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.idx_home)
        begin
            idx_next = IDX_W'(home_reg);
        end
        else if (ctl.idx_clear)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_plus1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            match_key      <= key_reg;
            probe_payload  <= pay_reg;
            stored_payload <= ctl.emit_pend ? pend_reg : '0;
            status         <= ctl.emit_status;
            last           <= ctl.emit_last;
        end
    end

    assign res_valid = out_valid_reg;

    // Slot table.
    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_HOME: rd_addr = ADDR_W'(home_reg);
            RD_IDX:  rd_addr = idx_reg[ADDR_W-1:0];
            RD_NEXT: rd_addr = idx_plus1[ADDR_W-1:0];
            default: rd_addr = idx_reg[ADDR_W-1:0];
        endcase
    end

    assign wr_en   = ctl.wr_insert || ctl.wr_clear;
    assign wr_addr = idx_reg[ADDR_W-1:0];
    assign wr_data = ctl.wr_clear ? {PAY_W'(0), empty_key_reg} : {pay_reg, key_reg};

    lph_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_key = rd_data[KEY_W-1:0];

    always_comb
    begin
        sts.cmd_opcode   = opcode;
        sts.op           = op_reg;
        sts.home_ok      = IDX_W'(home_reg) < IDX_W'(len_reg);
        sts.at_end       = idx_plus1 >= IDX_W'(len_reg);
        sts.at_depth_end = idx_reg == IDX_W'(TABLE_DEPTH - 1);
        sts.slot_empty   = slot_key == empty_key_reg;
        sts.slot_match   = slot_key == key_reg;
        sts.cnt_full     = cnt_reg == CNT_W'(MAX_MATCHES);
        sts.have_pend    = cnt_reg != '0;
        sts.unique_keys  = unique_reg;
        sts.out_free     = out_free;
    end
endmodule

`default_nettype wire

// ===== design/lph_ctrl.sv =====
// Controller: sequences clear sweeps, hashing and the slot walks of insert and probe.
`default_nettype none

module lph_ctrl
    import lph_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire lph_sts_t sts,
    output lph_ctl_t      ctl
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_HOME,
        S_START,
        S_WALK,
        S_FLUSH,
        S_CLEAR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = RD_IDX;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (sts.cmd_opcode)
                        OP_CLEAR:
                        begin
                            ctl.load      = 1'b1;
                            ctl.idx_clear = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_INSERT, OP_PROBE:
                        begin
                            ctl.load   = 1'b1;
                            state_next = S_HASH;
                        end
                        default:
                        begin
                            // An unused opcode is dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_HASH:
            begin
                state_next = S_HOME;
            end

            S_HOME:
            begin
                state_next = S_START;
            end

            S_START:
            begin
                ctl.cnt_clear = 1'b1;
                if (sts.home_ok)
                begin
                    ctl.idx_home = 1'b1;
                    ctl.rd_sel   = RD_HOME;
                    state_next   = S_WALK;
                end
                else if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = (sts.op == OP_INSERT) ? ST_FULL : ST_NOMATCH;
                    ctl.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_WALK:
            begin
                // The walk only moves while the result register can take an item,
                // so every branch below may emit in this cycle.
                if (sts.out_free)
                begin
                    if (sts.op == OP_INSERT)
                    begin
                        if (sts.slot_empty)
                        begin
                            ctl.wr_insert   = 1'b1;
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_INSERTED;
                            ctl.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (sts.at_end)
                        begin
                            ctl.emit        = 1'b1;
                            ctl.emit_status = ST_FULL;
                            ctl.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            ctl.idx_inc = 1'b1;
                            ctl.rd_sel  = RD_NEXT;
                        end
                    end
                    else
                    begin
                        if (sts.slot_empty)
                        begin
                            if (sts.have_pend)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_status = ST_NOMATCH;
                                ctl.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else if (sts.slot_match && sts.cnt_full)
                        begin
                            // One match too many: the held match closes the item.
                            ctl.emit        = 1'b1;
                            ctl.emit_pend   = 1'b1;
                            ctl.emit_status = ST_TRUNC;
                            ctl.emit_last   = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (sts.slot_match)
                        begin
                            // A match is held back until the walk shows whether it is last.
                            if (sts.have_pend)
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_pend   = 1'b1;
                                ctl.emit_status = ST_MATCH;
                            end
                            ctl.pend_load = 1'b1;
                            ctl.cnt_inc   = 1'b1;
                            if (sts.unique_keys || sts.at_end)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                ctl.idx_inc = 1'b1;
                                ctl.rd_sel  = RD_NEXT;
                            end
                        end
                        else if (sts.at_end)
                        begin
                            if (sts.have_pend)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                ctl.emit        = 1'b1;
                                ctl.emit_status = ST_NOMATCH;
                                ctl.emit_last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            ctl.idx_inc = 1'b1;
                            ctl.rd_sel  = RD_NEXT;
                        end
                    end
                end
            end

            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_pend   = 1'b1;
                    ctl.emit_status = ST_MATCH;
                    ctl.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                ctl.wr_clear = 1'b1;
                if (!sts.at_depth_end)
                begin
                    ctl.idx_inc = 1'b1;
                end
                else if (sts.out_free)
                begin
                    ctl.emit        = 1'b1;
                    ctl.emit_status = ST_CLEARED;
                    ctl.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== design/linear_probe_hash_build_probe_top.sv =====
// Top level of the linear probing hash table: controller, datapath and channel wiring.
//
//  Channel   Direction  Handshake        Carries
//  cmd       in         valid / ready    opcode, key, payload
//  res       out        valid / ready    match_key, probe_payload, stored_payload, status, last
//  cfg       in         cfg_write only   cfg_index, cfg_data
//
// Insert and probe pass through accept, two multiply stages and a home check, then walk
// the slots in order on the table's single read port, and a probe that ends on a held
// match adds a flush step. A clear sweeps the write port over all TABLE_DEPTH slots.
// One item is in work at a time; a full result register holds the walk. After reset
// the slot contents are undefined until the first clear.
`default_nettype none

module linear_probe_hash_build_probe_top
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_MATCHES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    lph_cmd_if.sink                    cmd,
    lph_res_if.source                  res
);
    lph_ctl_t ctl;
    lph_sts_t sts;
    logic     ready_w;

    assign cmd.ready = ready_w;

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (ready_w),
        .sts       (sts),
        .ctl       (ctl)
    );

    lph_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (cmd.opcode),
        .key            (cmd.key),
        .payload        (cmd.payload),
        .ctl            (ctl),
        .sts            (sts),
        .res_valid      (res.valid),
        .res_ready      (res.ready),
        .match_key      (res.match_key),
        .probe_payload  (res.probe_payload),
        .stored_payload (res.stored_payload),
        .status         (res.status),
        .last           (res.last)
    );
endmodule

`default_nettype wire

// ===== design/lph_checker.sv =====
// Port-level assertions for the hash table top level, bound to it.
`default_nettype none

module lph_checker
    import lph_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic [OPC_W-1:0]  cmd_opcode,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [PAY_W-1:0]  res_stored_payload,
    input wire logic [STAT_W-1:0] res_status,
    input wire logic              res_last
);
    // A stalled result item holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_last))
        else $error("result item changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status <= ST_TRUNC)
        else $error("result status out of range");

    // Only match and truncated results carry a slot payload, and every other kind closes its item.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_MATCH && res_status != ST_TRUNC
        |-> res_last && res_stored_payload == '0)
        else $error("non-match result is not a single final result");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_TRUNC |-> res_last)
        else $error("truncated probe result is not last");

    // A real command keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready
        && (cmd_opcode == OP_CLEAR || cmd_opcode == OP_INSERT || cmd_opcode == OP_PROBE)
        |=> !cmd_ready)
        else $error("command accepted while previous item in work");
endmodule

bind linear_probe_hash_build_probe_top lph_checker u_lph_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .cmd_opcode         (cmd.opcode),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_stored_payload (res.stored_payload),
    .res_status         (res.status),
    .res_last           (res.last)
);

`default_nettype wire

// ===== bench/linear_probe_hash_build_probe_top_test.sv =====
// Self-checking testbench for the linear probing hash table: predicted results against the result channel.
`timescale 1ns / 1ps

module linear_probe_hash_build_probe_top_test;
    import lph_pkg::*;

    localparam int SLOT_COUNT    = 1024;
    localparam int MATCH_LIMIT   = 64;
    localparam int IDLE_PCT      = 37;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 1100;
    localparam int STALL_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [KEY_W-1:0]  match_key;
        logic [PAY_W-1:0]  probe_payload;
        logic [PAY_W-1:0]  stored_payload;
        logic [STAT_W-1:0] status;
        logic              last;
    } hash_result_t;

    class join_table_scoreboard;
        logic [KEY_W-1:0]    hash_factor;
        logic [BUCKET_W-1:0] bucket_count;
        logic [KEY_W-1:0]    empty_key;
        logic                unique_keys;
        logic [KEY_W-1:0]    slot_key [SLOT_COUNT];
        logic [PAY_W-1:0]    slot_pay [SLOT_COUNT];
        hash_result_t        pending_results [$];
        int unsigned         mismatches;

        function new();
            hash_factor  = HASH_FACTOR_RST;
            bucket_count = BUCKET_COUNT_RST;
            empty_key    = '0;
            unique_keys  = 1'b0;
            mismatches   = 0;
            foreach (slot_key[i])
            begin
                slot_key[i] = '0;
                slot_pay[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HASH_FACTOR:  hash_factor  = data;
                CFG_BUCKET_COUNT: bucket_count = data[BUCKET_W-1:0];
                CFG_EMPTY_KEY:    empty_key    = data;
                CFG_UNIQUE_KEYS:  unique_keys  = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // Works out every result of one accepted command and updates the table copy.
        function void note_command(logic [OPC_W-1:0] op, logic [KEY_W-1:0] key,
                                   logic [PAY_W-1:0] pay);
            logic [KEY_W-1:0] mixed;
            logic [63:0]      scaled;
            int unsigned      home;
            int unsigned      len;
            hash_result_t     one;
            hash_result_t     found [$];
            mixed  = key * hash_factor;
            scaled = {32'd0, mixed} * {53'd0, bucket_count};
            home   = scaled[63:32];
            len    = (32'(bucket_count) * 32'd6) / 32'd5;
            if (len > SLOT_COUNT)
                len = SLOT_COUNT;
            one = '{key, pay, '0, ST_NOMATCH, 1'b0};
            case (op)
                OP_CLEAR:
                begin
                    foreach (slot_key[i])
                    begin
                        slot_key[i] = empty_key;
                        slot_pay[i] = '0;
                    end
                    one.status = ST_CLEARED;
                    found.push_back(one);
                end
                OP_INSERT:
                begin
                    one.status = ST_FULL;
                    for (int unsigned i = home; i < len; i++)
                    begin
                        if (slot_key[i] == empty_key)
                        begin
                            slot_key[i] = key;
                            slot_pay[i] = pay;
                            one.status = ST_INSERTED;
                            break;
                        end
                    end
                    found.push_back(one);
                end
                OP_PROBE:
                begin
                    for (int unsigned i = home; i < len; i++)
                    begin
                        if (slot_key[i] == empty_key)
                            break;
                        if (slot_key[i] == key)
                        begin
                            // A match beyond the limit only marks the final result.
                            if (found.size() >= MATCH_LIMIT)
                            begin
                                found[found.size()-1].status = ST_TRUNC;
                                break;
                            end
                            found.push_back('{key, pay, slot_pay[i], ST_MATCH, 1'b0});
                            if (unique_keys)
                                break;
                        end
                    end
                    if (found.size() == 0)
                        found.push_back(one);
                end
                default: ;
            endcase
            if (found.size() != 0)
                found[found.size()-1].last = 1'b1;
            foreach (found[i])
                pending_results.push_back(found[i]);
        endfunction

        function void check_result(hash_result_t got);
            hash_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing outstanding: key=%h probe=%h stored=%h status=%0d last=%b",
                             $realtime, got.match_key, got.probe_payload, got.stored_payload,
                             got.status, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.match_key !== want.match_key || got.probe_payload !== want.probe_payload
                || got.stored_payload !== want.stored_payload || got.status !== want.status
                || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected key=%h probe=%h stored=%h status=%0d last=%b",
                             want.match_key, want.probe_payload, want.stored_payload,
                             want.status, want.last);
                    $display("    actual   key=%h probe=%h stored=%h status=%0d last=%b",
                             got.match_key, got.probe_payload, got.stored_payload,
                             got.status, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;
    int unsigned           stall_cycles;
    join_table_scoreboard  sb;

    lph_cmd_if cmd_ch ();
    lph_res_if res_ch ();

    linear_probe_hash_build_probe_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.match_key, res_ch.probe_payload, res_ch.stored_payload,
                              res_ch.status, res_ch.last});
    end

    // Ends the run when neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_item(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= op;
        cmd_ch.key     <= key;
        cmd_ch.payload <= pay;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command(op, key, pay);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
        @(posedge clk);
    endtask

    // Registers change only with the block idle, after all outstanding results have drained.
    task automatic configure(input logic [KEY_W-1:0] factor, input logic [BUCKET_W-1:0] buckets,
                             input logic [KEY_W-1:0] empty, input logic uniq);
        cmd_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_HASH_FACTOR, factor);
        write_reg(CFG_BUCKET_COUNT, 32'(buckets));
        write_reg(CFG_EMPTY_KEY, empty);
        write_reg(CFG_UNIQUE_KEYS, 32'(uniq));
        cfg_write <= 1'b0;
    endtask

    // Mostly inserts and probes over a small key set so that chains grow and repeat.
    task automatic run_phase(input int count, input int key_set, input int insert_pct,
                             input int clear_pct, input bit start_clear, input bit quiet);
        logic [KEY_W-1:0] keys [$];
        logic [KEY_W-1:0] k;
        logic [OPC_W-1:0] op;
        int               pick;
        steady = quiet;
        repeat (key_set)
        begin
            k = $urandom;
            if (k == sb.empty_key)
                k = k ^ 32'd1;
            keys.push_back(k);
        end
        if (start_clear)
            send_item(OP_CLEAR, $urandom, $urandom);
        for (int n = 0; n < count; n++)
        begin
            if (n == 10 || $urandom_range(0, 99) < 2)
            begin
                cmd_ch.valid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < clear_pct)
                op = OP_CLEAR;
            else if (pick < clear_pct + 4)
                op = 2'd3;
            else if ($urandom_range(0, 99) < insert_pct)
                op = OP_INSERT;
            else
                op = OP_PROBE;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                k = $urandom;
            else if (pick < 12)
                k = sb.empty_key;
            else
                k = keys[$urandom_range(0, key_set - 1)];
            send_item(op, k, $urandom);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        steady         = 1'b0;
        stall_cycles   = 0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.opcode  = OP_CLEAR;
        cmd_ch.key     = '0;
        cmd_ch.payload = '0;
        res_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: basic build and probe with duplicates, empty key and an unused opcode.
        configure(HASH_FACTOR_RST, BUCKET_COUNT_RST, 32'd0, 1'b0);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_INSERT, 32'd1, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'd1, 32'h1234_5678);
        send_item(OP_PROBE, 32'd1, 32'hAAAA_5555);
        send_item(OP_PROBE, 32'hFFFF_FFFF, 32'h5555_AAAA);
        send_item(OP_PROBE, 32'd7, 32'd0);
        send_item(OP_INSERT, 32'd0, 32'd5);
        send_item(OP_PROBE, 32'd0, 32'd6);
        send_item(2'd3, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_item(OP_PROBE, 32'h8000_0000, 32'h8000_0001);

        // A table of one slot: the second key finds it full; unique mode on.
        configure(HASH_FACTOR_RST, 11'd1, 32'd0, 1'b1);
        send_item(OP_CLEAR, 32'd0, 32'd0);
        send_item(OP_INSERT, 32'd9, 32'h0000_0099);
        send_item(OP_INSERT, 32'd10, 32'h0000_0100);
        send_item(OP_INSERT, 32'd9, 32'h0000_0199);
        send_item(OP_PROBE, 32'd9, 32'h0000_0001);
        send_item(OP_PROBE, 32'd10, 32'h0000_0002);

        // No buckets at all: every walk is empty.
        configure(HASH_FACTOR_RST, 11'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_CLEAR, 32'd3, 32'd3);
        send_item(OP_INSERT, 32'd3, 32'd4);
        send_item(OP_PROBE, 32'd3, 32'd5);

        // Bucket count beyond the table: high home slots fall outside it.
        configure(32'hFFFF_FFFF, 11'd2047, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_CLEAR, 32'd0, 32'd0);
        send_item(OP_INSERT, 32'd1, 32'h1111_1111);
        send_item(OP_INSERT, 32'd0, 32'h2222_2222);
        send_item(OP_PROBE, 32'd0, 32'h3333_3333);
        send_item(OP_PROBE, 32'hFFFF_FFFF, 32'h4444_4444);

        configure(HASH_FACTOR_RST, BUCKET_COUNT_RST, 32'd0, 1'b0);
        run_phase(70, 24, 50, 3, 1'b1, 1'b0);

        // Every key hashes to slot zero, so one key piles up past the match limit.
        configure(32'd0, 11'd70, $urandom, 1'b0);
        run_phase(90, 1, 80, 0, 1'b1, 1'b0);

        configure(32'hFFFF_FFFF, 11'd1024, 32'hFFFF_FFFF, 1'b1);
        run_phase(60, 16, 55, 2, 1'b1, 1'b1);

        configure($urandom, 11'($urandom_range(1, 40)), $urandom, 1'($urandom));
        run_phase(70, 8, 60, 3, 1'b1, 1'b0);

        // The table is kept across this change.
        configure($urandom, 11'($urandom_range(0, 2047)), $urandom, 1'b0);
        run_phase(70, 12, 50, 3, 1'b0, 1'b0);

        cmd_ch.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lph_pkg.sv
design/lph_cmd_if.sv
design/lph_res_if.sv
design/lph_ram.sv
design/lph_datapath.sv
design/lph_ctrl.sv
design/linear_probe_hash_build_probe_top.sv
design/lph_checker.sv
bench/linear_probe_hash_build_probe_top_test.sv
